// ----- rtl/core/lpe_pkg.sv -----
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants for the line position estimator.
// ----------------------------------------------------------------------------
package lpe_pkg;

   localparam int NUM_SENSORS     = 8;
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int CSR_W           = 10;
   localparam int CSR_IDX_W       = 3;
   localparam int POS_W           = 13;
   localparam int POS_STEP        = 1000;
   localparam int POS_CENTER      = 3500;

   localparam logic [CSR_W-1:0] NOISE_THR_RST  = 10'd250;
   localparam logic [CSR_W-1:0] FLOOR_LOW_RST  = 10'd200;
   localparam logic [CSR_W-1:0] FLOOR_HIGH_RST = 10'd800;
   localparam logic [CSR_W-1:0] TURN_LOW_RST   = 10'd200;
   localparam logic [CSR_W-1:0] TURN_HIGH_RST  = 10'd800;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AUTO_FLOOR   = 3'd0,
      CSR_MANUAL_FLOOR = 3'd1,
      CSR_NOISE_THR    = 3'd2,
      CSR_FLOOR_LOW    = 3'd3,
      CSR_FLOOR_HIGH   = 3'd4,
      CSR_TURN_LOW     = 3'd5,
      CSR_TURN_HIGH    = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_START,
      ST_DIV,
      ST_HOLD
   } lpe_state_type;

   typedef struct packed {
      logic right_turn;
      logic left_turn;
   } turn_flags_type;

endpackage

// ----- rtl/core/lpe_accum.sv -----
// ----------------------------------------------------------------------------
// lpe_accum
// Walks the frame one sensor per cycle through a shift register: floor
// inversion, noise clamp, then running sum and index-weighted sum.
// ----------------------------------------------------------------------------
module lpe_accum #(
   parameter int SAMPLE_BITS = lpe_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               start,
   input  logic [lpe_pkg::NUM_SENSORS-1:0][SAMPLE_BITS-1:0]   samples,
   input  logic                                               invert,
   input  logic [lpe_pkg::CSR_W-1:0]                          noise_thr,
   output logic                                               done,
   output logic [SAMPLE_BITS+2:0]                             sum,
   output logic [SAMPLE_BITS+4:0]                             wsum
);
   import lpe_pkg::*;

   localparam int SUM_W = SAMPLE_BITS + 3;
   localparam int WSU_W = SAMPLE_BITS + 5;
   localparam int CMP_W = (SAMPLE_BITS > CSR_W) ? SAMPLE_BITS : CSR_W;
   localparam int IDX_W = $clog2(NUM_SENSORS);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

   logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] samp_ff, samp_in;
   logic [IDX_W-1:0]                        idx_ff, idx_in;
   logic                                    busy_ff, busy_in;
   logic                                    done_ff, done_in;
   logic [SUM_W-1:0]                        sum_ff, sum_in;
   logic [WSU_W-1:0]                        wsum_ff, wsum_in;
   logic [SAMPLE_BITS-1:0]                  d_raw;
   logic [SAMPLE_BITS-1:0]                  d_clip;

   always_comb begin
      d_raw  = invert ? (SAMPLE_MAX - samp_ff[0]) : samp_ff[0];
      d_clip = (CMP_W'(d_raw) < CMP_W'(noise_thr)) ? '0
             : SAMPLE_BITS'(CMP_W'(d_raw) - CMP_W'(noise_thr));
   end

   always_comb begin
      samp_in = samp_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum_in  = sum_ff;
      wsum_in = wsum_ff;
      if (start) begin
         samp_in = samples;
         idx_in  = '0;
         busy_in = 1'b1;
         sum_in  = '0;
         wsum_in = '0;
      end else if (busy_ff) begin
         samp_in = samp_ff >> SAMPLE_BITS;
         idx_in  = idx_ff + 1'b1;
         sum_in  = sum_ff + SUM_W'(d_clip);
         wsum_in = wsum_ff + WSU_W'(d_clip) * WSU_W'(idx_ff);
         if (idx_ff == IDX_W'(NUM_SENSORS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      samp_ff <= samp_in;
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      wsum_ff <= wsum_in;
   end

   assign done = done_ff;
   assign sum  = sum_ff;
   assign wsum = wsum_ff;

endmodule

// ----- rtl/core/lpe_divider.sv -----
// ----------------------------------------------------------------------------
// lpe_divider
// Restoring divider, one quotient bit per cycle. The divisor is pre-shifted
// to the top quotient bit and shifted right each step.
// ----------------------------------------------------------------------------
module lpe_divider #(
   parameter int SAMPLE_BITS = lpe_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [SAMPLE_BITS+14:0]       dividend,
   input  logic [SAMPLE_BITS+2:0]        divisor,
   output logic                          done,
   output logic [lpe_pkg::POS_W-1:0]     quotient
);
   import lpe_pkg::*;

   localparam int DIVD_W = SAMPLE_BITS + 15;
   localparam int CNT_W  = $clog2(POS_W + 1);

   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] den_ff, den_in;
   logic [POS_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   assign fits = (rem_ff >= den_ff);

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         den_in  = DIVD_W'(divisor) << (POS_W - 1);
         quo_in  = '0;
         cnt_in  = CNT_W'(POS_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_ff - den_ff) : rem_ff;
         quo_in = {quo_ff[POS_W-2:0], fits};
         den_in = den_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/line_position_estimator.sv -----
// Flow: an accepted frame passes through the sensor-serial accumulator, then
//   the bit-serial divider, then the output register; a new frame is accepted
//   only after the previous result has been loaded into the output register.
// Reset: synchronous, active high; clears control, loads register defaults,
//   white floor, held position 3500 and held error 0.
// ----------------------------------------------------------------------------
// line_position_estimator
// Weighted-centroid line position from a frame of eight reflectance samples,
// with floor detection and turn flags.
// ----------------------------------------------------------------------------
module line_position_estimator #(
   parameter int SAMPLE_BITS = lpe_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [lpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lpe_pkg::CSR_W-1:0]          csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [SAMPLE_BITS-1:0]             req_sample_0,
   input  logic [SAMPLE_BITS-1:0]             req_sample_1,
   input  logic [SAMPLE_BITS-1:0]             req_sample_2,
   input  logic [SAMPLE_BITS-1:0]             req_sample_3,
   input  logic [SAMPLE_BITS-1:0]             req_sample_4,
   input  logic [SAMPLE_BITS-1:0]             req_sample_5,
   input  logic [SAMPLE_BITS-1:0]             req_sample_6,
   input  logic [SAMPLE_BITS-1:0]             req_sample_7,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lpe_pkg::POS_W-1:0]          rsp_line_position,
   output logic signed [lpe_pkg::POS_W-1:0]   rsp_line_error,
   output logic                               rsp_line_seen,
   output logic                               rsp_floor_is_black,
   output logic                               rsp_right_turn,
   output logic                               rsp_left_turn
);
   import lpe_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + 3;
   localparam int WSU_W  = SAMPLE_BITS + 5;
   localparam int DIVD_W = SAMPLE_BITS + 15;
   localparam int CMP_W  = (SAMPLE_BITS > CSR_W) ? SAMPLE_BITS : CSR_W;

   lpe_state_type state_ff, state_in;

   logic             auto_floor_ff;
   logic             floor_black_ff, floor_black_in;
   logic [CSR_W-1:0] noise_thr_ff;
   logic [CSR_W-1:0] floor_low_ff;
   logic [CSR_W-1:0] floor_high_ff;
   logic [CSR_W-1:0] turn_low_ff;
   logic [CSR_W-1:0] turn_high_ff;

   logic [POS_W-1:0] held_pos_ff;
   logic [POS_W-1:0] held_err_ff;
   logic [POS_W-1:0] pos_out;
   logic [POS_W-1:0] err_out;

   logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] samples;
   logic [NUM_SENSORS-1:0][CMP_W-1:0]       samp_x;
   logic [NUM_SENSORS-1:0]                  below;
   logic [NUM_SENSORS-1:0]                  above;
   turn_flags_type                          turn_in;
   turn_flags_type                          turn_ff;

   logic              req_accept;
   logic              acc_start;
   logic              div_start;
   logic              out_load;
   logic              acc_done;
   logic [SUM_W-1:0]  acc_sum;
   logic [WSU_W-1:0]  acc_wsum;
   logic [SUM_W-1:0]  sum_ff;
   logic [DIVD_W-1:0] prod_ff;
   logic              div_done;
   logic [POS_W-1:0]  quotient;
   logic              seen;

   logic                   rsp_valid_ff;
   logic [POS_W-1:0]       rsp_pos_ff;
   logic [POS_W-1:0]       rsp_err_ff;
   logic                   rsp_seen_ff;
   logic                   rsp_floor_ff;
   turn_flags_type         rsp_turn_ff;

   assign samples = {req_sample_7, req_sample_6, req_sample_5, req_sample_4,
                     req_sample_3, req_sample_2, req_sample_1, req_sample_0};

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_floor_ff <= 1'b1;
         noise_thr_ff  <= NOISE_THR_RST;
         floor_low_ff  <= FLOOR_LOW_RST;
         floor_high_ff <= FLOOR_HIGH_RST;
         turn_low_ff   <= TURN_LOW_RST;
         turn_high_ff  <= TURN_HIGH_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_AUTO_FLOOR: auto_floor_ff <= csr_wdata[0];
            CSR_NOISE_THR:  noise_thr_ff  <= csr_wdata;
            CSR_FLOOR_LOW:  floor_low_ff  <= csr_wdata;
            CSR_FLOOR_HIGH: floor_high_ff <= csr_wdata;
            CSR_TURN_LOW:   turn_low_ff   <= csr_wdata;
            CSR_TURN_HIGH:  turn_high_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // floor detection and turn flags on the raw frame
   always_comb begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
         samp_x[i] = CMP_W'(samples[i]);
         below[i]  = samp_x[i] < CMP_W'(turn_low_ff);
         above[i]  = samp_x[i] > CMP_W'(turn_high_ff);
      end
      turn_in.right_turn = &below[3:0] & above[6] & above[7];
      turn_in.left_turn  = &below[7:4] & above[1] & above[0];

      floor_black_in = floor_black_ff;
      if (csr_write_enable && csr_index == CSR_MANUAL_FLOOR) begin
         floor_black_in = csr_wdata[0];
      end else if (req_accept && auto_floor_ff) begin
         if (samp_x[0] < CMP_W'(floor_low_ff) && samp_x[7] < CMP_W'(floor_low_ff)) begin
            floor_black_in = 1'b0;
         end
         if (samp_x[0] > CMP_W'(floor_high_ff) && samp_x[7] > CMP_W'(floor_high_ff)) begin
            floor_black_in = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_ACCUM;
         ST_ACCUM: if (acc_done) state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_HOLD;
         ST_HOLD:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_START: div_start = 1'b1;
         ST_HOLD:  out_load  = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign req_accept = req_valid && !req_stall;
   assign acc_start  = req_accept;

   lpe_accum #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .start     (acc_start),
      .samples   (samples),
      .invert    (floor_black_in),
      .noise_thr (noise_thr_ff),
      .done      (acc_done),
      .sum       (acc_sum),
      .wsum      (acc_wsum)
   );

   always_ff @(posedge clock) begin
      if (acc_done) begin
         sum_ff  <= acc_sum;
         prod_ff <= DIVD_W'(acc_wsum) * DIVD_W'(POS_STEP);
      end
      if (req_accept) begin
         turn_ff <= turn_in;
      end
   end

   lpe_divider #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign seen    = (sum_ff != '0);
   assign pos_out = seen ? quotient : held_pos_ff;
   assign err_out = seen ? (quotient - POS_W'(POS_CENTER)) : held_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         floor_black_ff <= 1'b0;
         held_pos_ff    <= POS_W'(POS_CENTER);
         held_err_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         floor_black_ff <= floor_black_in;
         if (out_load) begin
            held_pos_ff  <= pos_out;
            held_err_ff  <= err_out;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pos_ff   <= pos_out;
         rsp_err_ff   <= err_out;
         rsp_seen_ff  <= seen;
         rsp_floor_ff <= floor_black_ff;
         rsp_turn_ff  <= turn_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_position  = rsp_pos_ff;
   assign rsp_line_error     = $signed(rsp_err_ff);
   assign rsp_line_seen      = rsp_seen_ff;
   assign rsp_floor_is_black = rsp_floor_ff;
   assign rsp_right_turn     = rsp_turn_ff.right_turn;
   assign rsp_left_turn      = rsp_turn_ff.left_turn;

endmodule

// ----- rtl/core/lpe_checker.sv -----
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks on the line position estimator, bound to the top level.
// ----------------------------------------------------------------------------
module lpe_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [lpe_pkg::POS_W-1:0]          rsp_line_position,
   input  logic signed [lpe_pkg::POS_W-1:0]   rsp_line_error
);
   import lpe_pkg::*;

   logic [POS_W-1:0] err_expect;

   assign err_expect = rsp_line_position - POS_W'(POS_CENTER);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_position))
      else $error("rsp word changed while stalled");

   a_err_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $unsigned(rsp_line_error) == err_expect)
      else $error("line error does not match position");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_position <= POS_W'(7 * POS_STEP))
      else $error("line position out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !($rose(rsp_valid)))
      else $error("frame accepted without going busy");

endmodule

bind line_position_estimator lpe_checker u_lpe_checker (.*);
